FILE: sv/mips_alu_pkg.sv
package mips_alu_pkg;

	// ALU operations after decode
	typedef enum logic [3:0] {
		ALU_NONE  = 4'd0,
		ALU_ADD   = 4'd1,
		ALU_ADDU  = 4'd2,
		ALU_SUB   = 4'd3,
		ALU_SUBU  = 4'd4,
		ALU_AND   = 4'd5,
		ALU_OR    = 4'd6,
		ALU_XOR   = 4'd7,
		ALU_NOR   = 4'd8,
		ALU_SLT   = 4'd9,
		ALU_SLTU  = 4'd10,
		ALU_SLL   = 4'd11,
		ALU_SRL   = 4'd12,
		ALU_SRA   = 4'd13,
		ALU_LUI   = 4'd14,
		ALU_PASSA = 4'd15
	} alu_op_t;

	localparam int unsigned DATA_W    = 32;
	localparam int unsigned SHAMT_W   = 5;
	localparam int unsigned HALF_W    = 16;
	localparam int unsigned DEF_QUEUE_DEPTH = 2;

	// Decoded item carried from front to back
	typedef struct packed {
		alu_op_t              op;
		logic [DATA_W-1:0]    a;
		logic [DATA_W-1:0]    b;
		logic [SHAMT_W-1:0]   sh;
	} dec_item_t;

	// Write side of the decoded-item queue
	typedef struct packed {
		logic       push;
		dec_item_t  item;
	} dec_wr_t;

endpackage

FILE: sv/mips_alu_front.sv
module mips_alu_front (
	input  logic                                  push,
	output logic                                  full,
	input  logic [5:0]                            opcode,
	input  logic [5:0]                            funct,
	input  logic [mips_alu_pkg::DATA_W-1:0]       operand_a,
	input  logic [mips_alu_pkg::DATA_W-1:0]       operand_b,
	input  logic [mips_alu_pkg::SHAMT_W-1:0]      shift_amount,
	input  logic                                  q_full,
	output mips_alu_pkg::dec_wr_t                 wr
);

	// Primary opcodes
	localparam logic [5:0] OPC_RTYPE = 6'h00;
	localparam logic [5:0] OPC_BEQ   = 6'h04;
	localparam logic [5:0] OPC_BNE   = 6'h05;
	localparam logic [5:0] OPC_ADDI  = 6'h08;
	localparam logic [5:0] OPC_ADDIU = 6'h09;
	localparam logic [5:0] OPC_SLTI  = 6'h0A;
	localparam logic [5:0] OPC_SLTIU = 6'h0B;
	localparam logic [5:0] OPC_ANDI  = 6'h0C;
	localparam logic [5:0] OPC_ORI   = 6'h0D;
	localparam logic [5:0] OPC_XORI  = 6'h0E;
	localparam logic [5:0] OPC_LUI   = 6'h0F;
	localparam logic [5:0] OPC_LW    = 6'h23;
	localparam logic [5:0] OPC_LBU   = 6'h24;
	localparam logic [5:0] OPC_LHU   = 6'h25;
	localparam logic [5:0] OPC_SW    = 6'h2B;

	// Function codes under R format
	localparam logic [5:0] FN_SLL  = 6'h00;
	localparam logic [5:0] FN_SRL  = 6'h02;
	localparam logic [5:0] FN_SRA  = 6'h03;
	localparam logic [5:0] FN_SLLV = 6'h04;
	localparam logic [5:0] FN_SRLV = 6'h06;
	localparam logic [5:0] FN_JR   = 6'h08;
	localparam logic [5:0] FN_JALR = 6'h09;
	localparam logic [5:0] FN_ADD  = 6'h20;
	localparam logic [5:0] FN_ADDU = 6'h21;
	localparam logic [5:0] FN_SUB  = 6'h22;
	localparam logic [5:0] FN_SUBU = 6'h23;
	localparam logic [5:0] FN_AND  = 6'h24;
	localparam logic [5:0] FN_OR   = 6'h25;
	localparam logic [5:0] FN_XOR  = 6'h26;
	localparam logic [5:0] FN_NOR  = 6'h27;
	localparam logic [5:0] FN_SLT  = 6'h2A;
	localparam logic [5:0] FN_SLTU = 6'h2B;

	mips_alu_pkg::alu_op_t r_op;
	mips_alu_pkg::alu_op_t op;

	// Decode the function code
	always_comb begin
		case (funct)
			FN_SLL, FN_SLLV: r_op = mips_alu_pkg::ALU_SLL;
			FN_SRL, FN_SRLV: r_op = mips_alu_pkg::ALU_SRL;
			FN_SRA:          r_op = mips_alu_pkg::ALU_SRA;
			FN_JR, FN_JALR:  r_op = mips_alu_pkg::ALU_PASSA;
			FN_ADD:          r_op = mips_alu_pkg::ALU_ADD;
			FN_ADDU:         r_op = mips_alu_pkg::ALU_ADDU;
			FN_SUB:          r_op = mips_alu_pkg::ALU_SUB;
			FN_SUBU:         r_op = mips_alu_pkg::ALU_SUBU;
			FN_AND:          r_op = mips_alu_pkg::ALU_AND;
			FN_OR:           r_op = mips_alu_pkg::ALU_OR;
			FN_XOR:          r_op = mips_alu_pkg::ALU_XOR;
			FN_NOR:          r_op = mips_alu_pkg::ALU_NOR;
			FN_SLT:          r_op = mips_alu_pkg::ALU_SLT;
			FN_SLTU:         r_op = mips_alu_pkg::ALU_SLTU;
			default:         r_op = mips_alu_pkg::ALU_NONE;
		endcase
	end

	// Decode the primary opcode; memory ops use the adder and branches the subtractor
	always_comb begin
		case (opcode)
			OPC_RTYPE:                       op = r_op;
			OPC_BEQ, OPC_BNE:                op = mips_alu_pkg::ALU_SUBU;
			OPC_ADDI:                        op = mips_alu_pkg::ALU_ADD;
			OPC_ADDIU:                       op = mips_alu_pkg::ALU_ADDU;
			OPC_SLTI:                        op = mips_alu_pkg::ALU_SLT;
			OPC_SLTIU:                       op = mips_alu_pkg::ALU_SLTU;
			OPC_ANDI:                        op = mips_alu_pkg::ALU_AND;
			OPC_ORI:                         op = mips_alu_pkg::ALU_OR;
			OPC_XORI:                        op = mips_alu_pkg::ALU_XOR;
			OPC_LUI:                         op = mips_alu_pkg::ALU_LUI;
			OPC_LW, OPC_LBU, OPC_LHU, OPC_SW: op = mips_alu_pkg::ALU_ADDU;
			default:                         op = mips_alu_pkg::ALU_NONE;
		endcase
	end

	// Hand the classified item to the queue
	assign full        = q_full;
	assign wr.push     = push & ~q_full;
	assign wr.item.op  = op;
	assign wr.item.a   = operand_a;
	assign wr.item.b   = operand_b;
	assign wr.item.sh  = shift_amount;

endmodule

FILE: sv/mips_alu_queue.sv
module mips_alu_queue #(
	parameter int unsigned DEPTH = mips_alu_pkg::DEF_QUEUE_DEPTH
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  mips_alu_pkg::dec_wr_t    wr,
	output logic                     q_full,
	output logic                     q_valid,
	output mips_alu_pkg::dec_item_t  q_head,
	input  logic                     q_pop
);

	localparam int unsigned IDX_W = $clog2(DEPTH);
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	mips_alu_pkg::dec_item_t entry_q [DEPTH];
	logic [IDX_W-1:0] wr_ptr_q;
	logic [IDX_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_pop;

	assign do_pop  = q_pop & q_valid;
	assign q_full  = (count_q == FULL_CNT);
	assign q_valid = (count_q != '0);
	assign q_head  = entry_q[rd_ptr_q];

	// Store incoming items
	always_ff @(posedge clk) begin
		if (wr.push) begin
			entry_q[wr_ptr_q] <= wr.item;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr.push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_IDX) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_IDX) ? '0 : rd_ptr_q + 1'b1;
			end
			if (wr.push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (!wr.push && do_pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_no_overfill: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL_CNT)
		else $error("queue occupancy above depth");

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		!(wr.push && q_full))
		else $error("item written into full queue");

endmodule

FILE: sv/mips_alu_back.sv
module mips_alu_back (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  q_valid,
	input  mips_alu_pkg::dec_item_t               q_head,
	output logic                                  q_pop,
	output logic                                  empty,
	input  logic                                  pop,
	output logic [mips_alu_pkg::DATA_W-1:0]       result_value,
	output logic                                  zero_flag,
	output logic                                  overflow_flag,
	output logic                                  negative_flag,
	output logic                                  unsupported
);

	logic [mips_alu_pkg::DATA_W-1:0] a;
	logic [mips_alu_pkg::DATA_W-1:0] b;
	logic [mips_alu_pkg::DATA_W-1:0] v;
	logic                            ovf;
	logic                            none;
	logic                            take;

	logic                            out_valid_q;
	logic [mips_alu_pkg::DATA_W-1:0] value_q;
	logic                            zero_q;
	logic                            ovf_q;
	logic                            unsup_q;

	assign a    = q_head.a;
	assign b    = q_head.b;
	assign none = (q_head.op == mips_alu_pkg::ALU_NONE);

	// Move the head item into the output register when it is free or draining
	assign take  = q_valid & (~out_valid_q | pop);
	assign q_pop = take;

	// Execute the operation
	always_comb begin
		v   = '0;
		ovf = 1'b0;
		case (q_head.op)
			mips_alu_pkg::ALU_ADD: begin
				v   = a + b;
				ovf = ~(a[31] ^ b[31]) & (a[31] ^ v[31]);
			end
			mips_alu_pkg::ALU_ADDU:  v = a + b;
			mips_alu_pkg::ALU_SUB: begin
				v   = a - b;
				ovf = (a[31] ^ b[31]) & (a[31] ^ v[31]);
			end
			mips_alu_pkg::ALU_SUBU:  v = a - b;
			mips_alu_pkg::ALU_AND:   v = a & b;
			mips_alu_pkg::ALU_OR:    v = a | b;
			mips_alu_pkg::ALU_XOR:   v = a ^ b;
			mips_alu_pkg::ALU_NOR:   v = ~(a | b);
			mips_alu_pkg::ALU_SLT:
				v = {{(mips_alu_pkg::DATA_W-1){1'b0}}, ($signed(a) < $signed(b))};
			mips_alu_pkg::ALU_SLTU:
				v = {{(mips_alu_pkg::DATA_W-1){1'b0}}, (a < b)};
			mips_alu_pkg::ALU_SLL:   v = b << q_head.sh;
			mips_alu_pkg::ALU_SRL:   v = b >> q_head.sh;
			mips_alu_pkg::ALU_SRA:   v = $unsigned($signed(b) >>> q_head.sh);
			mips_alu_pkg::ALU_LUI:
				v = {b[mips_alu_pkg::HALF_W-1:0], {mips_alu_pkg::HALF_W{1'b0}}};
			mips_alu_pkg::ALU_PASSA: v = a;
			default: begin
				v   = '0;
				ovf = 1'b0;
			end
		endcase
	end

	// Hold the result until it is popped
	always_ff @(posedge clk) begin
		if (take) begin
			value_q <= v;
			zero_q  <= ~none & (v == '0);
			ovf_q   <= ovf;
			unsup_q <= none;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take) begin
			out_valid_q <= 1'b1;
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	assign empty         = ~out_valid_q;
	assign result_value  = value_q;
	assign zero_flag     = zero_q;
	assign overflow_flag = ovf_q;
	assign negative_flag = value_q[mips_alu_pkg::DATA_W-1];
	assign unsupported   = unsup_q;

	a_unsup_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && unsup_q) |->
			(value_q == '0) && !zero_q && !ovf_q)
		else $error("unsupported item carries nonzero result");

	a_take_fills: assert property (@(posedge clk) disable iff (!arst_n)
		take |=> out_valid_q)
		else $error("taken item did not reach output register");

endmodule

FILE: sv/mips_alu_with_control_decode_unit.sv
// Channel  | Direction | Handshake            | Payload
// ---------+-----------+----------------------+-------------------------------------------
// input    | in        | push / full          | opcode, funct, operand_a, operand_b,
//          |           |                      | shift_amount
// result   | out       | empty / pop          | result_value, zero_flag, overflow_flag,
//          |           |                      | negative_flag, unsupported
//
// One item per cycle sustained while pop is high; the accepting edge writes the decoded
// item into the queue, whose head is executed into the output register, where it shows
// on the result ports. The output register empties and refills in the same cycle when pop
// is high, so the rate is set by the single execute unit, one operation per cycle.
// arst_n clears the queue occupancy and the output valid; full and empty come out low/high.
// A stalled result side holds one item in the output register and QUEUE_DEPTH items in the
// queue, then full rises.
module mips_alu_with_control_decode_unit #(
	parameter int unsigned QUEUE_DEPTH = mips_alu_pkg::DEF_QUEUE_DEPTH
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  push,
	output logic                                  full,
	input  logic [5:0]                            opcode,
	input  logic [5:0]                            funct,
	input  logic [mips_alu_pkg::DATA_W-1:0]       operand_a,
	input  logic [mips_alu_pkg::DATA_W-1:0]       operand_b,
	input  logic [mips_alu_pkg::SHAMT_W-1:0]      shift_amount,
	output logic                                  empty,
	input  logic                                  pop,
	output logic [mips_alu_pkg::DATA_W-1:0]       result_value,
	output logic                                  zero_flag,
	output logic                                  overflow_flag,
	output logic                                  negative_flag,
	output logic                                  unsupported
);

	mips_alu_pkg::dec_wr_t   wr;
	mips_alu_pkg::dec_item_t q_head;
	logic                    q_full;
	logic                    q_valid;
	logic                    q_pop;

	// Classify incoming items
	mips_alu_front u_front (
		.push         (push),
		.full         (full),
		.opcode       (opcode),
		.funct        (funct),
		.operand_a    (operand_a),
		.operand_b    (operand_b),
		.shift_amount (shift_amount),
		.q_full       (q_full),
		.wr           (wr)
	);

	// Buffer decoded items between front and back
	mips_alu_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (wr),
		.q_full  (q_full),
		.q_valid (q_valid),
		.q_head  (q_head),
		.q_pop   (q_pop)
	);

	// Execute and hold results
	mips_alu_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_valid       (q_valid),
		.q_head        (q_head),
		.q_pop         (q_pop),
		.empty         (empty),
		.pop           (pop),
		.result_value  (result_value),
		.zero_flag     (zero_flag),
		.overflow_flag (overflow_flag),
		.negative_flag (negative_flag),
		.unsupported   (unsupported)
	);

endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
	import mips_alu_pkg::*;

	// primary opcodes
	localparam logic [5:0] OPC_RTYPE = 6'h00;
	localparam logic [5:0] OPC_J     = 6'h02;
	localparam logic [5:0] OPC_JAL   = 6'h03;
	localparam logic [5:0] OPC_BEQ   = 6'h04;
	localparam logic [5:0] OPC_BNE   = 6'h05;
	localparam logic [5:0] OPC_ADDI  = 6'h08;
	localparam logic [5:0] OPC_ADDIU = 6'h09;
	localparam logic [5:0] OPC_SLTI  = 6'h0A;
	localparam logic [5:0] OPC_SLTIU = 6'h0B;
	localparam logic [5:0] OPC_ANDI  = 6'h0C;
	localparam logic [5:0] OPC_ORI   = 6'h0D;
	localparam logic [5:0] OPC_XORI  = 6'h0E;
	localparam logic [5:0] OPC_LUI   = 6'h0F;
	localparam logic [5:0] OPC_LW    = 6'h23;
	localparam logic [5:0] OPC_LBU   = 6'h24;
	localparam logic [5:0] OPC_LHU   = 6'h25;
	localparam logic [5:0] OPC_SW    = 6'h2B;
	localparam logic [5:0] OPC_LAST  = 6'h3F;

	// R-format function codes
	localparam logic [5:0] FN_SLL  = 6'h00;
	localparam logic [5:0] FN_SRL  = 6'h02;
	localparam logic [5:0] FN_SRA  = 6'h03;
	localparam logic [5:0] FN_SLLV = 6'h04;
	localparam logic [5:0] FN_SRLV = 6'h06;
	localparam logic [5:0] FN_SRAV = 6'h07;
	localparam logic [5:0] FN_JR   = 6'h08;
	localparam logic [5:0] FN_JALR = 6'h09;
	localparam logic [5:0] FN_ADD  = 6'h20;
	localparam logic [5:0] FN_ADDU = 6'h21;
	localparam logic [5:0] FN_SUB  = 6'h22;
	localparam logic [5:0] FN_SUBU = 6'h23;
	localparam logic [5:0] FN_AND  = 6'h24;
	localparam logic [5:0] FN_OR   = 6'h25;
	localparam logic [5:0] FN_XOR  = 6'h26;
	localparam logic [5:0] FN_NOR  = 6'h27;
	localparam logic [5:0] FN_SLT  = 6'h2A;
	localparam logic [5:0] FN_SLTU = 6'h2B;
	localparam logic [5:0] FN_LAST = 6'h3F;

	localparam int RANDOM_ITEMS = 1100;
	localparam int MAX_WAIT     = 18;

	typedef struct {
		logic [5:0]         opc;
		logic [5:0]         fn;
		logic [DATA_W-1:0]  a;
		logic [DATA_W-1:0]  b;
		logic [SHAMT_W-1:0] sh;
		int                 gap;
	} instr_t;

	typedef struct {
		logic [DATA_W-1:0] value;
		logic              zero;
		logic              ovf;
		logic              neg;
		logic              unsup;
	} alu_out_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               push = 1'b0;
	logic               full;
	logic [5:0]         opcode = '0;
	logic [5:0]         funct = '0;
	logic [DATA_W-1:0]  operand_a = '0;
	logic [DATA_W-1:0]  operand_b = '0;
	logic [SHAMT_W-1:0] shift_amount = '0;
	logic               empty;
	logic               pop = 1'b0;
	logic [DATA_W-1:0]  result_value;
	logic               zero_flag;
	logic               overflow_flag;
	logic               negative_flag;
	logic               unsupported;

	instr_t   instr_queue[$];
	alu_out_t alu_results_due[$];
	instr_t   cur;
	logic     have_cur = 1'b0;
	logic     in_taken = 1'b0;
	logic     out_taken = 1'b0;
	logic     push_calm = 1'b0;
	logic     pop_calm = 1'b0;
	int       stall_cnt = 0;
	int       err_count = 0;
	int       items_in = 0;
	int       results_out = 0;
	int       unsup_seen = 0;
	int       ovf_seen = 0;
	int       zero_seen = 0;

	mips_alu_with_control_decode_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.full          (full),
		.opcode        (opcode),
		.funct         (funct),
		.operand_a     (operand_a),
		.operand_b     (operand_b),
		.shift_amount  (shift_amount),
		.empty         (empty),
		.pop           (pop),
		.result_value  (result_value),
		.zero_flag     (zero_flag),
		.overflow_flag (overflow_flag),
		.negative_flag (negative_flag),
		.unsupported   (unsupported)
	);

	// map opcode and funct to an ALU operation
	function automatic alu_op_t decode_alu_op(logic [5:0] opc, logic [5:0] fn);
		if (opc == OPC_RTYPE) begin
			case (fn)
			FN_SLL, FN_SLLV: return ALU_SLL;
			FN_SRL, FN_SRLV: return ALU_SRL;
			FN_SRA:          return ALU_SRA;
			FN_JR, FN_JALR:  return ALU_PASSA;
			FN_ADD:          return ALU_ADD;
			FN_ADDU:         return ALU_ADDU;
			FN_SUB:          return ALU_SUB;
			FN_SUBU:         return ALU_SUBU;
			FN_AND:          return ALU_AND;
			FN_OR:           return ALU_OR;
			FN_XOR:          return ALU_XOR;
			FN_NOR:          return ALU_NOR;
			FN_SLT:          return ALU_SLT;
			FN_SLTU:         return ALU_SLTU;
			default:         return ALU_NONE;
			endcase
		end
		case (opc)
		OPC_BEQ, OPC_BNE:                    return ALU_SUBU;
		OPC_ADDI:                            return ALU_ADD;
		OPC_ADDIU:                           return ALU_ADDU;
		OPC_SLTI:                            return ALU_SLT;
		OPC_SLTIU:                           return ALU_SLTU;
		OPC_ANDI:                            return ALU_AND;
		OPC_ORI:                             return ALU_OR;
		OPC_XORI:                            return ALU_XOR;
		OPC_LUI:                             return ALU_LUI;
		OPC_LW, OPC_LBU, OPC_LHU, OPC_SW:    return ALU_ADDU;
		default:                             return ALU_NONE;
		endcase
	endfunction

	// compute the result the ALU owes for one instruction
	function automatic alu_out_t predict_alu(instr_t it);
		alu_out_t    r;
		alu_op_t     op;
		logic [DATA_W-1:0] v;
		logic        ovf;
		op = decode_alu_op(it.opc, it.fn);
		v = '0;
		ovf = 1'b0;
		case (op)
		ALU_ADD: begin
			v = it.a + it.b;
			ovf = (it.a[DATA_W-1] == it.b[DATA_W-1]) && (v[DATA_W-1] != it.a[DATA_W-1]);
		end
		ALU_ADDU: v = it.a + it.b;
		ALU_SUB: begin
			v = it.a - it.b;
			ovf = (it.a[DATA_W-1] != it.b[DATA_W-1]) && (v[DATA_W-1] != it.a[DATA_W-1]);
		end
		ALU_SUBU:  v = it.a - it.b;
		ALU_AND:   v = it.a & it.b;
		ALU_OR:    v = it.a | it.b;
		ALU_XOR:   v = it.a ^ it.b;
		ALU_NOR:   v = ~(it.a | it.b);
		ALU_SLT:   v = ($signed(it.a) < $signed(it.b)) ? 1 : 0;
		ALU_SLTU:  v = (it.a < it.b) ? 1 : 0;
		ALU_SLL:   v = it.b << it.sh;
		ALU_SRL:   v = it.b >> it.sh;
		ALU_SRA:   v = $unsigned($signed(it.b) >>> it.sh);
		ALU_LUI:   v = it.b << HALF_W;
		ALU_PASSA: v = it.a;
		default:   v = '0;
		endcase
		if (op == ALU_NONE) begin
			r.value = '0;
			r.zero = 1'b0;
			r.ovf = 1'b0;
			r.neg = 1'b0;
			r.unsup = 1'b1;
		end else begin
			r.value = v;
			r.zero = (v == '0);
			r.ovf = ovf;
			r.neg = v[DATA_W-1];
			r.unsup = 1'b0;
		end
		return r;
	endfunction

	// sender gap, with calm stretches of back-to-back items
	function automatic int draw_gap();
		if ($urandom_range(0, 29) == 0)
			push_calm = !push_calm;
		return push_calm ? 0 : $urandom_range(0, MAX_WAIT);
	endfunction

	function automatic logic [DATA_W-1:0] draw_operand();
		case ($urandom_range(0, 9))
		6: begin
			case ($urandom_range(0, 4))
			0:       return 32'h0000_0000;
			1:       return 32'h0000_0001;
			2:       return 32'h7FFF_FFFF;
			3:       return 32'h8000_0000;
			default: return 32'hFFFF_FFFF;
			endcase
		end
		7:       return $urandom_range(0, 15);
		8:       return 32'hFFFF_FFF0 | $urandom_range(0, 15);
		9:       return 32'h7FFF_FFF8 + $urandom_range(0, 15);
		default: return $urandom;
		endcase
	endfunction

	function automatic logic [5:0] pick_funct();
		case ($urandom_range(0, 17))
		0:       return FN_SLL;
		1:       return FN_SRL;
		2:       return FN_SRA;
		3:       return FN_SLLV;
		4:       return FN_SRLV;
		5:       return FN_JR;
		6:       return FN_JALR;
		7:       return FN_ADD;
		8:       return FN_ADDU;
		9:       return FN_SUB;
		10:      return FN_SUBU;
		11:      return FN_AND;
		12:      return FN_OR;
		13:      return FN_XOR;
		14:      return FN_NOR;
		15:      return FN_SLT;
		16:      return FN_SLTU;
		default: return 6'($urandom_range(0, FN_LAST));
		endcase
	endfunction

	function automatic logic [5:0] pick_opcode();
		case ($urandom_range(0, 15))
		0:       return OPC_BEQ;
		1:       return OPC_BNE;
		2:       return OPC_ADDI;
		3:       return OPC_ADDIU;
		4:       return OPC_SLTI;
		5:       return OPC_SLTIU;
		6:       return OPC_ANDI;
		7:       return OPC_ORI;
		8:       return OPC_XORI;
		9:       return OPC_LUI;
		10:      return OPC_LW;
		11:      return OPC_LBU;
		12:      return OPC_LHU;
		13:      return OPC_SW;
		default: return 6'($urandom_range(0, OPC_LAST));
		endcase
	endfunction

	task automatic add_instr(logic [5:0] opc, logic [5:0] fn, logic [DATA_W-1:0] a,
			logic [DATA_W-1:0] b, logic [SHAMT_W-1:0] sh);
		instr_t it;
		it.opc = opc;
		it.fn = fn;
		it.a = a;
		it.b = b;
		it.sh = sh;
		it.gap = draw_gap();
		instr_queue.push_back(it);
	endtask

	task automatic check_field(string name, logic [DATA_W-1:0] want, logic [DATA_W-1:0] got);
		if (want !== got) begin
			$error("%s mismatch: expected %0h, got %0h", name, want, got);
			err_count++;
		end
	endtask

	// clock and reset
	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	// hold the current item until taken, then wait its gap and present the next
	always @(negedge clk) begin : push_drv
		logic go;
		go = 1'b0;
		if (arst_n && !(push && !in_taken)) begin
			if (!have_cur && instr_queue.size() != 0) begin
				cur = instr_queue.pop_front();
				have_cur = 1'b1;
			end
			if (have_cur && cur.gap == 0) begin
				go = 1'b1;
				have_cur = 1'b0;
			end else if (have_cur) begin
				cur.gap--;
			end
			if (go) begin
				opcode <= cur.opc;
				funct <= cur.fn;
				operand_a <= cur.a;
				operand_b <= cur.b;
				shift_amount <= cur.sh;
			end else begin
				// scramble idle inputs; they must be ignored
				opcode <= 6'($urandom);
				funct <= 6'($urandom);
				operand_a <= DATA_W'($urandom);
				operand_b <= DATA_W'($urandom);
				shift_amount <= SHAMT_W'($urandom);
			end
			push <= go;
		end
	end

	// draw a stall after each taken result, with calm stretches
	always @(negedge clk) begin
		if (arst_n && !(pop && !out_taken)) begin
			if (pop) begin
				if ($urandom_range(0, 39) == 0)
					pop_calm = !pop_calm;
				stall_cnt = pop_calm ? 0 : $urandom_range(0, MAX_WAIT);
			end
			if (stall_cnt == 0) begin
				pop <= 1'b1;
			end else begin
				pop <= 1'b0;
				stall_cnt--;
			end
		end
	end

	// record accepted items and compare accepted results
	always @(posedge clk) begin : monitor
		instr_t   seen;
		alu_out_t want;
		if (arst_n) begin
			in_taken <= push && !full;
			out_taken <= pop && !empty;
			if (push && !full) begin
				seen.opc = opcode;
				seen.fn = funct;
				seen.a = operand_a;
				seen.b = operand_b;
				seen.sh = shift_amount;
				seen.gap = 0;
				alu_results_due.push_back(predict_alu(seen));
				items_in++;
			end
			if (pop && !empty) begin
				results_out++;
				if (alu_results_due.size() == 0) begin
					$error("result with no item outstanding: value %0h", result_value);
					err_count++;
				end else begin
					want = alu_results_due.pop_front();
					check_field("result_value", want.value, result_value);
					check_field("zero_flag", DATA_W'(want.zero), DATA_W'(zero_flag));
					check_field("overflow_flag", DATA_W'(want.ovf), DATA_W'(overflow_flag));
					check_field("negative_flag", DATA_W'(want.neg), DATA_W'(negative_flag));
					check_field("unsupported", DATA_W'(want.unsup), DATA_W'(unsupported));
					unsup_seen += want.unsup;
					ovf_seen += want.ovf;
					zero_seen += want.zero;
				end
			end
		end
	end

	// stimulus and end of run
	initial begin
		logic [5:0]        opc;
		logic [DATA_W-1:0] a;
		logic [DATA_W-1:0] b;

		// directed: extremes, each operation, unsupported encodings
		add_instr(OPC_RTYPE, FN_ADD, 32'h7FFF_FFFF, 32'h0000_0001, 5'd0);
		add_instr(OPC_RTYPE, FN_SUB, 32'h8000_0000, 32'h0000_0001, 5'd31);
		add_instr(OPC_RTYPE, FN_ADDU, 32'hFFFF_FFFF, 32'h0000_0001, 5'd0);
		add_instr(OPC_BEQ, FN_LAST, 32'h1234_5678, 32'h1234_5678, 5'd0);
		add_instr(OPC_BNE, FN_SLL, 32'h0000_0000, 32'hFFFF_FFFF, 5'd0);
		add_instr(OPC_RTYPE, FN_SUBU, 32'h0000_0000, 32'h0000_0001, 5'd0);
		add_instr(OPC_RTYPE, FN_AND, 32'hFFFF_FFFF, 32'hA5A5_5A5A, 5'd0);
		add_instr(OPC_RTYPE, FN_OR, 32'h0000_0000, 32'h0000_0000, 5'd0);
		add_instr(OPC_RTYPE, FN_XOR, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 5'd0);
		add_instr(OPC_RTYPE, FN_NOR, 32'h0000_0000, 32'h0000_0000, 5'd0);
		add_instr(OPC_RTYPE, FN_SLT, 32'h8000_0000, 32'h7FFF_FFFF, 5'd0);
		add_instr(OPC_RTYPE, FN_SLTU, 32'h8000_0000, 32'h7FFF_FFFF, 5'd0);
		add_instr(OPC_RTYPE, FN_SLL, 32'hFFFF_FFFF, 32'h0000_0001, 5'd31);
		add_instr(OPC_RTYPE, FN_SRLV, 32'h0000_0000, 32'h8000_0000, 5'd31);
		add_instr(OPC_RTYPE, FN_SRA, 32'h0000_0000, 32'h8000_0000, 5'd31);
		add_instr(OPC_RTYPE, FN_SRA, 32'h0000_0000, 32'h8000_0000, 5'd0);
		add_instr(OPC_LUI, FN_LAST, 32'hFFFF_FFFF, 32'hFFFF_ABCD, 5'd0);
		add_instr(OPC_RTYPE, FN_JALR, 32'h8000_0004, 32'h0000_0000, 5'd0);
		add_instr(OPC_RTYPE, FN_SRAV, 32'hFFFF_FFFF, 32'h8000_0000, 5'd4);
		add_instr(OPC_J, FN_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 5'd31);
		add_instr(OPC_JAL, FN_ADD, 32'h0000_0001, 32'h0000_0001, 5'd1);
		add_instr(OPC_LAST, FN_LAST, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 5'd31);
		add_instr(OPC_ADDI, FN_LAST, 32'h8000_0000, 32'hFFFF_FFFF, 5'd0);
		add_instr(OPC_ORI, FN_SRAV, 32'h0000_00F0, 32'h0000_000F, 5'd0);
		add_instr(OPC_SW, FN_JR, 32'hFFFF_FFFC, 32'h0000_0004, 5'd0);

		// random: mostly decodable instructions, some arbitrary encodings
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			opc = ($urandom_range(0, 1) == 0) ? OPC_RTYPE : pick_opcode();
			a = draw_operand();
			case ($urandom_range(0, 9))
			0:       b = a;
			1:       b = -a;
			2:       b = ~a;
			default: b = draw_operand();
			endcase
			add_instr(opc, (opc == OPC_RTYPE) ? pick_funct() : 6'($urandom_range(0, FN_LAST)),
				a, b, SHAMT_W'($urandom_range(0, 31)));
		end

		// drain: all items taken, all results back, then a short tail
		while (instr_queue.size() != 0 || have_cur || push)
			@(posedge clk);
		while (alu_results_due.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		$display("Ran %0d instructions, %0d results checked: %0d unsupported, %0d overflow,",
			items_in, results_out, unsup_seen, ovf_seen);
		$display("%0d zero results, with random gaps and stalls on both sides.", zero_seen);
		if (err_count == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

	// watchdog
	initial begin
		#5_000_000;
		$display("Some tests failed");
		$finish;
	end

endmodule
